/* hw/rtl/lkt_pkg.sv */
// shared types and codes for the learned key table
`default_nettype none

package lkt_pkg;

    // field widths of one transaction on each side
    localparam int KEY_FIELD_W    = 32;
    localparam int RELAY_FIELD_W  = 16;
    localparam int WINDOW_FIELD_W = 8;
    localparam int SLOT_FIELD_W   = 4;

    // command codes
    localparam logic CMD_LEARN = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        OUT_FULL    = 2'd0,
        OUT_NEW     = 2'd1,
        OUT_UPDATED = 2'd2,
        OUT_CLEARED = 2'd3
    } t_outcome;

    // input transaction
    typedef struct packed {
        logic                      cmd;
        logic [KEY_FIELD_W-1:0]    switch_key;
        logic [RELAY_FIELD_W-1:0]  relay_state;
        logic [WINDOW_FIELD_W-1:0] window_one_state;
        logic [WINDOW_FIELD_W-1:0] window_two_state;
    } t_in_item;

    // result transaction
    typedef struct packed {
        t_outcome                outcome;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic                    slot_valid;
    } t_out_item;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // sequencer status toward the top level
    typedef struct packed {
        logic in_ready;
        logic done;
    } t_ctrl_status;

endpackage

`default_nettype wire

/* hw/rtl/learned_key_table.sv */
// learned key table top level: handshakes, output register, slot scan
//
//  channel | direction | payload              | handshake
//  in      | input     | lkt_pkg::t_in_item   | i_in_valid / o_in_ready
//  out     | output    | lkt_pkg::t_out_item  | o_out_valid / i_out_ready
//
// one command scans every slot when no slot matches, fewer on an early match;
// the single key comparator walks one slot per cycle over the key memory's
// registered read port, then the command finishes in the commit state.
// reset clears the occupancy map, not the key memory; key memory needs no clearing pass.
// the commit waits while the output register holds an untaken result.
`default_nettype none

module learned_key_table #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int RELAY_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire lkt_pkg::t_in_item  i_in_data,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      lkt_pkg::t_out_item o_out_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    lkt_pkg::t_ctrl_status             status;
    lkt_pkg::t_out_item                result;
    logic                              accept;
    logic                              res_free;
    logic                              we;
    logic [IDX_W-1:0]                  waddr;
    logic [KEY_BITS-1:0]               wkey;
    logic [RELAY_BITS-1:0]             wrelay;
    logic [lkt_pkg::WINDOW_FIELD_W-1:0] wwin_one;
    logic [lkt_pkg::WINDOW_FIELD_W-1:0] wwin_two;
    logic [IDX_W-1:0]                  raddr;
    logic [KEY_BITS-1:0]               rkey;

    logic               r_out_valid, n_out_valid;
    lkt_pkg::t_out_item r_out_data, n_out_data;

    // input handshake
    assign o_in_ready = status.in_ready;
    assign accept     = i_in_valid && status.in_ready;
    assign res_free   = !r_out_valid || i_out_ready;

    // output register next value
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (status.done) begin
            n_out_valid = 1'b1;
            n_out_data  = result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // scan sequencer
    lkt_scan_ctrl #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .RELAY_BITS (RELAY_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .i_res_free (res_free),
        .o_status   (status),
        .o_result   (result),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wkey     (wkey),
        .o_wrelay   (wrelay),
        .o_wwin_one (wwin_one),
        .o_wwin_two (wwin_two),
        .o_raddr    (raddr),
        .i_rkey     (rkey)
    );

    // slot memory
    lkt_entry_store #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .RELAY_BITS (RELAY_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_we       (we),
        .i_waddr    (waddr),
        .i_wkey     (wkey),
        .i_wrelay   (wrelay),
        .i_wwin_one (wwin_one),
        .i_wwin_two (wwin_two),
        .i_raddr    (raddr),
        .o_rkey     (rkey)
    );

endmodule

`default_nettype wire

/* hw/rtl/lkt_entry_store.sv */
// slot memory: stored keys with a registered read port, plus entry data
`default_nettype none

module lkt_entry_store #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int RELAY_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [IDX_W-1:0]                  i_waddr,
    input  wire logic [KEY_BITS-1:0]               i_wkey,
    input  wire logic [RELAY_BITS-1:0]             i_wrelay,
    input  wire logic [lkt_pkg::WINDOW_FIELD_W-1:0] i_wwin_one,
    input  wire logic [lkt_pkg::WINDOW_FIELD_W-1:0] i_wwin_two,
    input  wire logic [IDX_W-1:0]                  i_raddr,
    output      logic [KEY_BITS-1:0]               o_rkey
);

    localparam int DATA_W = RELAY_BITS + 2 * lkt_pkg::WINDOW_FIELD_W;

    logic [KEY_BITS-1:0] r_keys [SLOTS];
    logic [DATA_W-1:0]   r_data [SLOTS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_keys[i_waddr] <= i_wkey;
            r_data[i_waddr] <= {i_wrelay, i_wwin_one, i_wwin_two};
        end
    end

    // registered key read
    always_ff @(posedge i_clk) begin
        o_rkey <= r_keys[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/lkt_scan_ctrl.sv */
// scan sequencer: walks the slots through one key comparator, then commits
`default_nettype none

module lkt_scan_ctrl #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int RELAY_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire lkt_pkg::t_in_item                 i_item,
    input  wire logic                              i_res_free,
    output      lkt_pkg::t_ctrl_status             o_status,
    output      lkt_pkg::t_out_item                o_result,
    output      logic                              o_we,
    output      logic [IDX_W-1:0]                  o_waddr,
    output      logic [KEY_BITS-1:0]               o_wkey,
    output      logic [RELAY_BITS-1:0]             o_wrelay,
    output      logic [lkt_pkg::WINDOW_FIELD_W-1:0] o_wwin_one,
    output      logic [lkt_pkg::WINDOW_FIELD_W-1:0] o_wwin_two,
    output      logic [IDX_W-1:0]                  o_raddr,
    input  wire logic [KEY_BITS-1:0]               i_rkey
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    lkt_pkg::t_state                   r_state, n_state;
    logic                              r_cmd, n_cmd;
    logic [KEY_BITS-1:0]               r_key, n_key;
    logic [RELAY_BITS-1:0]             r_relay, n_relay;
    logic [lkt_pkg::WINDOW_FIELD_W-1:0] r_win_one, n_win_one;
    logic [lkt_pkg::WINDOW_FIELD_W-1:0] r_win_two, n_win_two;
    logic [IDX_W-1:0]                  r_idx, n_idx;
    logic                              r_issue, n_issue;
    logic                              r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0]                  r_cmp_idx, n_cmp_idx;
    logic                              r_free_found, n_free_found;
    logic [IDX_W-1:0]                  r_free_idx, n_free_idx;
    logic                              r_hit, n_hit;
    logic [IDX_W-1:0]                  r_slot, n_slot;
    logic [SLOTS-1:0]                  r_occ, n_occ;

    logic cmp_used;
    logic cmp_hit;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lkt_pkg::ST_IDLE;
            r_occ        <= '0;
            r_issue      <= 1'b0;
            r_cmp_valid  <= 1'b0;
            r_free_found <= 1'b0;
            r_hit        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_issue      <= n_issue;
            r_cmp_valid  <= n_cmp_valid;
            r_free_found <= n_free_found;
            r_hit        <= n_hit;
        end
    end

    // captured command and scan positions
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_relay    <= n_relay;
        r_win_one  <= n_win_one;
        r_win_two  <= n_win_two;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_free_idx <= n_free_idx;
        r_slot     <= n_slot;
    end

    // shared comparator on the registered key read
    assign cmp_used = r_occ[r_cmp_idx];
    assign cmp_hit  = r_cmp_valid && cmp_used && (i_rkey == r_key);

    // next state and outputs
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_relay      = r_relay;
        n_win_one    = r_win_one;
        n_win_two    = r_win_two;
        n_idx        = r_idx;
        n_issue      = r_issue;
        n_cmp_valid  = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_occ        = r_occ;

        o_status.in_ready = 1'b0;
        o_status.done     = 1'b0;
        o_result.outcome    = lkt_pkg::OUT_FULL;
        o_result.slot_index = '0;
        o_result.slot_valid = 1'b0;
        o_we       = 1'b0;
        o_waddr    = r_slot;
        o_wkey     = r_key;
        o_wrelay   = r_relay;
        o_wwin_one = r_win_one;
        o_wwin_two = r_win_two;
        o_raddr    = r_idx;

        case (r_state)
            lkt_pkg::ST_IDLE: begin
                o_status.in_ready = 1'b1;
                if (i_accept) begin
                    n_cmd        = i_item.cmd;
                    n_key        = KEY_BITS'(i_item.switch_key);
                    n_relay      = RELAY_BITS'(i_item.relay_state);
                    n_win_one    = i_item.window_one_state;
                    n_win_two    = i_item.window_two_state;
                    n_idx        = '0;
                    n_issue      = 1'b1;
                    n_free_found = 1'b0;
                    n_hit        = 1'b0;
                    n_state      = lkt_pkg::ST_SCAN;
                end
            end

            lkt_pkg::ST_SCAN: begin
                // issue one slot read per cycle
                if (r_issue) begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // remember the lowest free slot
                if (r_cmp_valid && !cmp_used && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                // lowest match ends the scan early
                if (cmp_hit) begin
                    n_hit       = 1'b1;
                    n_slot      = r_cmp_idx;
                    n_issue     = 1'b0;
                    n_cmp_valid = 1'b0;
                    n_state     = lkt_pkg::ST_COMMIT;
                end else if (r_cmp_valid && r_cmp_idx == LAST_IDX) begin
                    n_cmp_valid = 1'b0;
                    n_state     = lkt_pkg::ST_COMMIT;
                end
            end

            lkt_pkg::ST_COMMIT: begin
                if (r_cmd == lkt_pkg::CMD_CLEAR) begin
                    o_result.outcome = lkt_pkg::OUT_CLEARED;
                    if (r_hit) begin
                        o_result.slot_index = lkt_pkg::SLOT_FIELD_W'(r_slot);
                        o_result.slot_valid = 1'b1;
                    end
                end else if (r_hit) begin
                    o_result.outcome    = lkt_pkg::OUT_UPDATED;
                    o_result.slot_index = lkt_pkg::SLOT_FIELD_W'(r_slot);
                    o_result.slot_valid = 1'b1;
                end else if (r_free_found) begin
                    o_result.outcome    = lkt_pkg::OUT_NEW;
                    o_result.slot_index = lkt_pkg::SLOT_FIELD_W'(r_free_idx);
                    o_result.slot_valid = 1'b1;
                    o_waddr             = r_free_idx;
                end
                // write back once the output register can take the result
                if (i_res_free) begin
                    o_status.done = 1'b1;
                    n_state       = lkt_pkg::ST_IDLE;
                    if (r_cmd == lkt_pkg::CMD_CLEAR) begin
                        if (r_hit) begin
                            n_occ[r_slot] = 1'b0;
                        end
                    end else if (r_hit || r_free_found) begin
                        o_we           = 1'b1;
                        n_occ[o_waddr] = 1'b1;
                    end
                end
            end

            default: begin
                n_state = lkt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/lkt_checker.sv */
// port-level checks for the learned key table, bound to the top level
`default_nettype none

module lkt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire lkt_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire lkt_pkg::t_out_item o_out_data
);

    // a command occupies the block: no new transaction right after one
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("input taken again right after a transaction");

    // a stalled result holds
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data))
    ) else $error("result changed while stalled");

    // no slot used means slot index zero
    a_idle_slot_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.slot_valid) |-> (o_out_data.slot_index == '0)
    ) else $error("slot index set without a slot");

    // learn outcomes agree with the slot flag
    a_outcome_flag: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.outcome == lkt_pkg::OUT_FULL && !o_out_data.slot_valid) ||
             (o_out_data.outcome == lkt_pkg::OUT_NEW && o_out_data.slot_valid) ||
             (o_out_data.outcome == lkt_pkg::OUT_UPDATED && o_out_data.slot_valid) ||
             (o_out_data.outcome == lkt_pkg::OUT_CLEARED))
    ) else $error("outcome and slot flag disagree");

endmodule

bind learned_key_table lkt_checker u_lkt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
